FILE: rtl/core/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants of the single-wire bus master
// Holds the command codes, register indexes, reset values and the records
// that carry the timing registers and the per-tick result.
// ----------------------------------------------------------------------------
package owbm_pkg;

    localparam int TICK_W    = 10;
    localparam int REG_IDX_W = 3;
    localparam int BIT_IDX_W = 3;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 2;

    typedef logic [TICK_W-1:0]    ticks_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [BIT_IDX_W-1:0] bit_idx_t;
    typedef logic [BYTE_W-1:0]    byte_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    localparam reg_idx_t REG_RESET_LOW    = 3'd0;
    localparam reg_idx_t REG_RESET_HIGH   = 3'd1;
    localparam reg_idx_t REG_RESET_SETTLE = 3'd2;
    localparam reg_idx_t REG_READ_LEAD    = 3'd3;
    localparam reg_idx_t REG_READ_SAMPLE  = 3'd4;
    localparam reg_idx_t REG_READ_TAIL    = 3'd5;
    localparam reg_idx_t REG_WRITE_LEAD   = 3'd6;
    localparam reg_idx_t REG_WRITE_SLOT   = 3'd7;

    localparam ticks_t RST_RESET_LOW    = 10'd500;
    localparam ticks_t RST_RESET_HIGH   = 10'd260;
    localparam ticks_t RST_RESET_SETTLE = 10'd10;
    localparam ticks_t RST_READ_LEAD    = 10'd80;
    localparam ticks_t RST_READ_SAMPLE  = 10'd10;
    localparam ticks_t RST_READ_TAIL    = 10'd40;
    localparam ticks_t RST_WRITE_LEAD   = 10'd120;
    localparam ticks_t RST_WRITE_SLOT   = 10'd65;

    typedef struct packed {
        ticks_t reset_low_ticks;
        ticks_t reset_high_ticks;
        ticks_t reset_settle_ticks;
        ticks_t read_lead_ticks;
        ticks_t read_sample_ticks;
        ticks_t read_tail_ticks;
        ticks_t write_lead_ticks;
        ticks_t write_slot_ticks;
    } cfg_t;

    typedef struct packed {
        logic  drive_low;
        logic  busy_res;
        byte_t rx_byte;
        logic  done_res;
    } res_t;

endpackage

FILE: rtl/core/owbm_cfg.sv
// ----------------------------------------------------------------------------
// owbm_cfg: timing register file
// Eight 10-bit timing registers written through a plain indexed write port.
// ----------------------------------------------------------------------------
module owbm_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  owbm_pkg::reg_idx_t cfg_addr,
    input  owbm_pkg::ticks_t   cfg_wdata,
    output owbm_pkg::cfg_t     cfg
);

    owbm_pkg::cfg_t cfg_reg;
    owbm_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                owbm_pkg::REG_RESET_LOW:    cfg_next.reset_low_ticks    = cfg_wdata;
                owbm_pkg::REG_RESET_HIGH:   cfg_next.reset_high_ticks   = cfg_wdata;
                owbm_pkg::REG_RESET_SETTLE: cfg_next.reset_settle_ticks = cfg_wdata;
                owbm_pkg::REG_READ_LEAD:    cfg_next.read_lead_ticks    = cfg_wdata;
                owbm_pkg::REG_READ_SAMPLE:  cfg_next.read_sample_ticks  = cfg_wdata;
                owbm_pkg::REG_READ_TAIL:    cfg_next.read_tail_ticks    = cfg_wdata;
                owbm_pkg::REG_WRITE_LEAD:   cfg_next.write_lead_ticks   = cfg_wdata;
                owbm_pkg::REG_WRITE_SLOT:   cfg_next.write_slot_ticks   = cfg_wdata;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_ticks    <= owbm_pkg::RST_RESET_LOW;
            cfg_reg.reset_high_ticks   <= owbm_pkg::RST_RESET_HIGH;
            cfg_reg.reset_settle_ticks <= owbm_pkg::RST_RESET_SETTLE;
            cfg_reg.read_lead_ticks    <= owbm_pkg::RST_READ_LEAD;
            cfg_reg.read_sample_ticks  <= owbm_pkg::RST_READ_SAMPLE;
            cfg_reg.read_tail_ticks    <= owbm_pkg::RST_READ_TAIL;
            cfg_reg.write_lead_ticks   <= owbm_pkg::RST_WRITE_LEAD;
            cfg_reg.write_slot_ticks   <= owbm_pkg::RST_WRITE_SLOT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/owbm_seq.sv
// ----------------------------------------------------------------------------
// owbm_seq: bus phase sequencer
// Advances the bus phase by one tick per transfer and produces the line drive,
// busy, done and received byte of that tick.
// ----------------------------------------------------------------------------
module owbm_seq #(
    parameter int BITS_PER_BYTE = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  owbm_pkg::cmd_t   cmd,
    input  owbm_pkg::byte_t  tx_byte,
    input  logic             line_level,
    input  owbm_pkg::cfg_t   cfg,
    output owbm_pkg::res_t   res
);

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_RST_LOW    = 4'd1,
        PH_RST_HIGH   = 4'd2,
        PH_RST_SETTLE = 4'd3,
        PH_RST_POLL   = 4'd4,
        PH_W_LEAD     = 4'd5,
        PH_W_PULSE    = 4'd6,
        PH_W_HOLD     = 4'd7,
        PH_R_LEAD     = 4'd8,
        PH_R_PULSE    = 4'd9,
        PH_R_WAIT     = 4'd10,
        PH_R_TAIL     = 4'd11
    } phase_t;

    localparam logic [owbm_pkg::BIT_IDX_W:0] BIT_LIMIT =
        (owbm_pkg::BIT_IDX_W + 1)'(BITS_PER_BYTE);

    phase_t             phase_reg, phase_next;
    owbm_pkg::ticks_t   tick_reg, tick_next;
    owbm_pkg::bit_idx_t bit_reg, bit_next;
    owbm_pkg::byte_t    shift_reg, shift_next;
    owbm_pkg::byte_t    result_reg, result_next;

    logic                           drive;
    logic                           done;
    logic                           last_bit;
    logic [owbm_pkg::TICK_W:0]      cnt;
    owbm_pkg::ticks_t               len;
    owbm_pkg::ticks_t               len_raw;

    always_comb begin
        phase_t start_phase;
        start_phase = phase_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        result_next = result_reg;
        drive       = 1'b0;
        done        = 1'b0;
        cnt         = '0;

        if (phase_reg == PH_IDLE && cmd != owbm_pkg::CMD_TICK) begin
            tick_next = '0;
            bit_next  = '0;
            case (cmd)
                owbm_pkg::CMD_RESET: start_phase = PH_RST_LOW;
                owbm_pkg::CMD_WRITE: begin
                    shift_next  = tx_byte;
                    start_phase = (cfg.write_lead_ticks == '0) ? PH_W_PULSE : PH_W_LEAD;
                end
                default: begin
                    shift_next  = '0;
                    start_phase = (cfg.read_lead_ticks == '0) ? PH_R_PULSE : PH_R_LEAD;
                end
            endcase
        end
        phase_next = start_phase;

        case (start_phase)
            PH_RST_LOW:    len_raw = cfg.reset_low_ticks;
            PH_RST_HIGH:   len_raw = cfg.reset_high_ticks;
            PH_RST_SETTLE: len_raw = cfg.reset_settle_ticks;
            PH_R_LEAD:     len_raw = cfg.read_lead_ticks;
            PH_R_WAIT:     len_raw = cfg.read_sample_ticks;
            PH_R_TAIL:     len_raw = cfg.read_tail_ticks;
            PH_W_LEAD:     len_raw = cfg.write_lead_ticks;
            PH_W_HOLD:     len_raw = cfg.write_slot_ticks;
            default:       len_raw = owbm_pkg::TICK_W'(1);
        endcase

        // Zero length acts as one tick
        len = (len_raw == '0) ? owbm_pkg::TICK_W'(1) : len_raw;

        last_bit = (({1'b0, bit_next} + 4'd1) >= BIT_LIMIT);

        if (start_phase != PH_IDLE) begin
            if (start_phase == PH_RST_LOW || start_phase == PH_W_PULSE
                || start_phase == PH_R_PULSE) begin
                drive = 1'b1;
            end else if (start_phase == PH_W_HOLD) begin
                drive = ~shift_next[0];
            end

            if (start_phase == PH_RST_POLL) begin
                if (line_level) begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
            end else begin
                cnt = {1'b0, tick_next} + (owbm_pkg::TICK_W + 1)'(1);
                if (cnt >= {1'b0, len}) begin
                    tick_next = '0;
                    case (start_phase)
                        PH_RST_LOW:    phase_next = PH_RST_HIGH;
                        PH_RST_HIGH:   phase_next = PH_RST_SETTLE;
                        PH_RST_SETTLE: phase_next = PH_RST_POLL;
                        PH_W_LEAD:     phase_next = PH_W_PULSE;
                        PH_W_PULSE:    phase_next = PH_W_HOLD;
                        PH_W_HOLD: begin
                            shift_next = shift_next >> 1;
                            if (last_bit) begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end else begin
                                bit_next   = bit_next + 3'd1;
                                phase_next = PH_W_PULSE;
                            end
                        end
                        PH_R_LEAD:     phase_next = PH_R_PULSE;
                        PH_R_PULSE: begin
                            shift_next = shift_next >> 1;
                            phase_next = PH_R_WAIT;
                        end
                        PH_R_WAIT: begin
                            if (line_level) begin
                                shift_next[owbm_pkg::BYTE_W-1] = 1'b1;
                            end
                            phase_next = PH_R_TAIL;
                        end
                        PH_R_TAIL: begin
                            if (last_bit) begin
                                result_next = shift_next;
                                phase_next  = PH_IDLE;
                                done        = 1'b1;
                            end else begin
                                bit_next   = bit_next + 3'd1;
                                phase_next = PH_R_PULSE;
                            end
                        end
                        default:       phase_next = PH_IDLE;
                    endcase
                end else begin
                    tick_next = cnt[owbm_pkg::TICK_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= '0;
            bit_reg    <= '0;
            shift_reg  <= '0;
            result_reg <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            result_reg <= result_next;
        end
    end

    assign res.drive_low = drive;
    assign res.busy_res  = (phase_next != PH_IDLE);
    assign res.rx_byte   = result_next;
    assign res.done_res  = done;

`ifndef SYNTHESIS
    a_idle_tick_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> tick_reg == '0)
        else $error("tick count not cleared in idle");

    a_bit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, bit_reg} < BIT_LIMIT)
        else $error("bit index beyond byte width");

    a_hold_without_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(phase_reg) && $stable(tick_reg) && $stable(shift_reg))
        else $error("sequencer moved without a transfer");
`endif

endmodule

FILE: rtl/core/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master: single-wire bus master, one microsecond tick per transfer
// Latency: the result of a tick is valid the cycle after its input transfer.
// Throughput: one tick per cycle; the output register frees while m_ready is high.
// Bus phase logic and the result register are the only stages in the path.
// Reset (aresetn low, synchronous): bus idle, timing registers at defaults,
// no result pending.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
    parameter int BITS_PER_BYTE = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [owbm_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [owbm_pkg::TICK_W-1:0]  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [owbm_pkg::CMD_W-1:0]   s_cmd,
    input  logic [owbm_pkg::BYTE_W-1:0]  s_tx_byte,
    input  logic                         s_line_level,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_drive_low,
    output logic                         m_busy_res,
    output logic [owbm_pkg::BYTE_W-1:0]  m_rx_byte,
    output logic                         m_done_res
);

    owbm_pkg::cfg_t cfg;
    owbm_pkg::res_t res;
    owbm_pkg::res_t res_reg;
    logic           m_valid_reg, m_valid_next;
    logic           xfer;

    owbm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (owbm_pkg::reg_idx_t'(cfg_addr)),
        .cfg_wdata (owbm_pkg::ticks_t'(cfg_wdata)),
        .cfg       (cfg)
    );

    owbm_seq #(
        .BITS_PER_BYTE (BITS_PER_BYTE)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (xfer),
        .cmd        (owbm_pkg::cmd_t'(s_cmd)),
        .tx_byte    (s_tx_byte),
        .line_level (s_line_level),
        .cfg        (cfg),
        .res        (res)
    );

    assign s_ready      = !m_valid_reg || m_ready;
    assign xfer         = s_valid && s_ready;
    assign m_valid_next = xfer || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (xfer) begin
            res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_drive_low = res_reg.drive_low;
    assign m_busy_res  = res_reg.busy_res;
    assign m_rx_byte   = res_reg.rx_byte;
    assign m_done_res  = res_reg.done_res;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_done_res |-> !m_busy_res)
        else $error("done reported while still busy");
`endif

endmodule

FILE: dv/tb_one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master: self-checking bench for the single-wire bus master
// Sends one tick per transfer and keeps a cycle-accurate copy of the bus phase
// logic beside the design. Every result transfer is compared field by field
// with the output computed for its tick. Directed tests cover reset timing,
// zero and full-scale registers, byte extremes and retiming mid-operation;
// random traffic follows, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;

    localparam int          BITS_PER_BYTE  = 8;
    localparam int          NUM_REGS       = 8;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT    = 2000000;
    localparam int unsigned DRAIN_PAD      = 8;
    localparam int unsigned RANDOM_SETS    = 5;
    localparam int unsigned ITEMS_PER_SET  = 40;
    localparam int unsigned DEFAULT_TICKS  = 95;
    localparam int unsigned MAX_TICKS      = 40;

    localparam int LINE_RANDOM = 0;
    localparam int LINE_LOW    = 1;
    localparam int LINE_HIGH   = 2;

    typedef enum logic [3:0] {
        BUS_IDLE, RST_LOW, RST_HIGH, RST_SETTLE, RST_POLL,
        WR_LEAD, WR_PULSE, WR_HOLD, RD_LEAD, RD_PULSE, RD_WAIT, RD_TAIL
    } bus_phase_t;

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               cfg_wr_en    = 1'b0;
    owbm_pkg::reg_idx_t cfg_addr     = '0;
    owbm_pkg::ticks_t   cfg_wdata    = '0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    owbm_pkg::cmd_t     s_cmd        = owbm_pkg::CMD_TICK;
    owbm_pkg::byte_t    s_tx_byte    = '0;
    logic               s_line_level = 1'b1;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic               m_drive_low;
    logic               m_busy_res;
    owbm_pkg::byte_t    m_rx_byte;
    logic               m_done_res;

    one_wire_bus_master #(
        .BITS_PER_BYTE(BITS_PER_BYTE)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_tx_byte   (s_tx_byte),
        .s_line_level(s_line_level),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_drive_low (m_drive_low),
        .m_busy_res  (m_busy_res),
        .m_rx_byte   (m_rx_byte),
        .m_done_res  (m_done_res)
    );

    always #1 aclk = ~aclk;

    // bus master copy
    owbm_pkg::ticks_t timing_regs[NUM_REGS];
    owbm_pkg::ticks_t cfg_plan[NUM_REGS];
    bus_phase_t       bus_ph;
    owbm_pkg::ticks_t tick_cnt;
    int unsigned      bit_idx;
    owbm_pkg::byte_t  shreg;
    owbm_pkg::byte_t  rx_last;

    owbm_pkg::res_t   tick_outputs_q[$];
    owbm_pkg::res_t   want_out;
    int unsigned      mismatch_count = 0;
    int unsigned      cycle_count    = 0;

    bit tx_idle_en  = 1'b0;
    bit rx_stall_en = 1'b0;
    bit rx_hold_req = 1'b0;
    int line_mode   = LINE_RANDOM;
    int poll_low_left = 0;

    function automatic void reset_bus_copy();
        timing_regs[owbm_pkg::REG_RESET_LOW]    = owbm_pkg::RST_RESET_LOW;
        timing_regs[owbm_pkg::REG_RESET_HIGH]   = owbm_pkg::RST_RESET_HIGH;
        timing_regs[owbm_pkg::REG_RESET_SETTLE] = owbm_pkg::RST_RESET_SETTLE;
        timing_regs[owbm_pkg::REG_READ_LEAD]    = owbm_pkg::RST_READ_LEAD;
        timing_regs[owbm_pkg::REG_READ_SAMPLE]  = owbm_pkg::RST_READ_SAMPLE;
        timing_regs[owbm_pkg::REG_READ_TAIL]    = owbm_pkg::RST_READ_TAIL;
        timing_regs[owbm_pkg::REG_WRITE_LEAD]   = owbm_pkg::RST_WRITE_LEAD;
        timing_regs[owbm_pkg::REG_WRITE_SLOT]   = owbm_pkg::RST_WRITE_SLOT;
        cfg_plan = timing_regs;
        bus_ph   = BUS_IDLE;
        tick_cnt = '0;
        bit_idx  = 0;
        shreg    = '0;
        rx_last  = '0;
    endfunction

    function automatic int unsigned phase_len(bus_phase_t ph);
        owbm_pkg::ticks_t v;
        case (ph)
            RST_LOW:    v = timing_regs[owbm_pkg::REG_RESET_LOW];
            RST_HIGH:   v = timing_regs[owbm_pkg::REG_RESET_HIGH];
            RST_SETTLE: v = timing_regs[owbm_pkg::REG_RESET_SETTLE];
            RD_LEAD:    v = timing_regs[owbm_pkg::REG_READ_LEAD];
            RD_WAIT:    v = timing_regs[owbm_pkg::REG_READ_SAMPLE];
            RD_TAIL:    v = timing_regs[owbm_pkg::REG_READ_TAIL];
            WR_LEAD:    v = timing_regs[owbm_pkg::REG_WRITE_LEAD];
            WR_HOLD:    v = timing_regs[owbm_pkg::REG_WRITE_SLOT];
            default:    v = 10'd1;
        endcase
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic owbm_pkg::res_t step_bus_master(owbm_pkg::cmd_t c,
                                                       owbm_pkg::byte_t tx, logic lvl);
        owbm_pkg::res_t r;
        int unsigned    cnt;
        bit             last;
        r = '0;
        if (bus_ph == BUS_IDLE && c != owbm_pkg::CMD_TICK) begin
            tick_cnt = '0;
            bit_idx  = 0;
            case (c)
                owbm_pkg::CMD_RESET: begin
                    bus_ph = RST_LOW;
                end
                owbm_pkg::CMD_WRITE: begin
                    shreg  = tx;
                    bus_ph = (timing_regs[owbm_pkg::REG_WRITE_LEAD] == '0) ? WR_PULSE
                                                                           : WR_LEAD;
                end
                default: begin
                    shreg  = '0;
                    bus_ph = (timing_regs[owbm_pkg::REG_READ_LEAD] == '0) ? RD_PULSE
                                                                          : RD_LEAD;
                end
            endcase
        end
        if (bus_ph != BUS_IDLE) begin
            r.drive_low = (bus_ph == RST_LOW || bus_ph == WR_PULSE || bus_ph == RD_PULSE);
            if (bus_ph == WR_HOLD)
                r.drive_low = ~shreg[0];
            if (bus_ph == RST_POLL) begin
                if (lvl) begin
                    bus_ph     = BUS_IDLE;
                    r.done_res = 1'b1;
                end
            end else begin
                cnt  = int'(tick_cnt) + 1;
                last = (bit_idx + 1 >= BITS_PER_BYTE);
                if (cnt < phase_len(bus_ph)) begin
                    tick_cnt = owbm_pkg::ticks_t'(cnt);
                end else begin
                    tick_cnt = '0;
                    case (bus_ph)
                        RST_LOW:    bus_ph = RST_HIGH;
                        RST_HIGH:   bus_ph = RST_SETTLE;
                        RST_SETTLE: bus_ph = RST_POLL;
                        WR_LEAD:    bus_ph = WR_PULSE;
                        WR_PULSE:   bus_ph = WR_HOLD;
                        WR_HOLD: begin
                            shreg = shreg >> 1;
                            if (last) begin
                                bus_ph     = BUS_IDLE;
                                r.done_res = 1'b1;
                            end else begin
                                bit_idx = bit_idx + 1;
                                bus_ph  = WR_PULSE;
                            end
                        end
                        RD_LEAD:    bus_ph = RD_PULSE;
                        RD_PULSE: begin
                            shreg  = shreg >> 1;
                            bus_ph = RD_WAIT;
                        end
                        RD_WAIT: begin
                            if (lvl)
                                shreg[7] = 1'b1;
                            bus_ph = RD_TAIL;
                        end
                        RD_TAIL: begin
                            if (last) begin
                                rx_last    = shreg;
                                bus_ph     = BUS_IDLE;
                                r.done_res = 1'b1;
                            end else begin
                                bit_idx = bit_idx + 1;
                                bus_ph  = RD_PULSE;
                            end
                        end
                        default:    bus_ph = BUS_IDLE;
                    endcase
                end
            end
        end
        r.busy_res = (bus_ph != BUS_IDLE);
        r.rx_byte  = rx_last;
        return r;
    endfunction

    function automatic int unsigned pick_gap(int unsigned min_len);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return min_len;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic pick_line();
        if (bus_ph == RST_POLL) begin
            if (poll_low_left > 0) begin
                poll_low_left = poll_low_left - 1;
                return 1'b0;
            end
            return (line_mode == LINE_RANDOM) ? 1'($urandom_range(0, 1)) : 1'b1;
        end
        case (line_mode)
            LINE_LOW:  return 1'b0;
            LINE_HIGH: return 1'b1;
            default:   return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic owbm_pkg::cmd_t busy_cmd();
        if ($urandom_range(0, 3) == 0)
            return owbm_pkg::cmd_t'($urandom_range(0, 3));
        return owbm_pkg::CMD_TICK;
    endfunction

    function automatic void plan_all(owbm_pkg::ticks_t v);
        for (int i = 0; i < NUM_REGS; i++)
            cfg_plan[i] = v;
    endfunction

    task automatic send_tick(owbm_pkg::cmd_t c, owbm_pkg::byte_t tx, logic lvl);
        int unsigned gap;
        s_valid      <= 1'b1;
        s_cmd        <= c;
        s_tx_byte    <= tx;
        s_line_level <= lvl;
        do @(posedge aclk); while (!s_ready);
        tick_outputs_q.push_back(step_bus_master(c, tx, lvl));
        gap = tx_idle_en ? pick_gap(0) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tick_outputs_q.size() != 0);
    endtask

    task automatic apply_timing();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= owbm_pkg::reg_idx_t'(i);
            cfg_wdata <= cfg_plan[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        timing_regs = cfg_plan;
    endtask

    task automatic finish_op();
        while (bus_ph != BUS_IDLE)
            send_tick(busy_cmd(), owbm_pkg::byte_t'($urandom), pick_line());
    endtask

    task automatic run_op(owbm_pkg::cmd_t c, owbm_pkg::byte_t tx);
        finish_op();
        send_tick(c, tx, pick_line());
        finish_op();
    endtask

    task automatic retime_op(owbm_pkg::cmd_t c, bus_phase_t at_ph, owbm_pkg::reg_idx_t idx,
                             owbm_pkg::ticks_t first_len, owbm_pkg::ticks_t later_len);
        drain();
        plan_all(10'd4);
        cfg_plan[idx] = first_len;
        apply_timing();
        run_op(owbm_pkg::CMD_TICK, 8'h00);
        send_tick(c, owbm_pkg::byte_t'($urandom), pick_line());
        while (!(bus_ph == at_ph && tick_cnt >= 10'd8))
            send_tick(owbm_pkg::CMD_TICK, owbm_pkg::byte_t'($urandom), pick_line());
        drain();
        cfg_plan[idx] = later_len;
        apply_timing();
        finish_op();
    endtask

    task automatic test_default_timing();
        line_mode = LINE_RANDOM;
        send_tick(owbm_pkg::CMD_READ, 8'h00, pick_line());
        repeat (DEFAULT_TICKS)
            send_tick(owbm_pkg::CMD_TICK, owbm_pkg::byte_t'($urandom), pick_line());
        drain();
        plan_all(10'd2);
        apply_timing();
        finish_op();
    endtask

    task automatic test_zero_timing();
        drain();
        plan_all(10'd0);
        apply_timing();
        poll_low_left = 3;
        run_op(owbm_pkg::CMD_RESET, 8'h00);
        run_op(owbm_pkg::CMD_WRITE, 8'h00);
        line_mode = LINE_LOW;
        run_op(owbm_pkg::CMD_READ, 8'hFF);
        line_mode = LINE_HIGH;
        run_op(owbm_pkg::CMD_READ, 8'h00);
        line_mode = LINE_RANDOM;
    endtask

    task automatic test_byte_extremes();
        drain();
        plan_all(10'd2);
        apply_timing();
        send_tick(owbm_pkg::CMD_TICK, 8'hFF, 1'b1);
        send_tick(owbm_pkg::CMD_TICK, 8'h00, 1'b0);
        run_op(owbm_pkg::CMD_WRITE, 8'hFF);
        run_op(owbm_pkg::CMD_WRITE, 8'h01);
        run_op(owbm_pkg::CMD_WRITE, 8'h80);
        run_op(owbm_pkg::CMD_READ, 8'h00);
        send_tick(owbm_pkg::CMD_WRITE, 8'h5A, 1'b1);
        send_tick(owbm_pkg::CMD_READ, 8'hC3, 1'b0);
        send_tick(owbm_pkg::CMD_RESET, 8'h3C, 1'b1);
        finish_op();
    endtask

    task automatic test_retime_mid_phase();
        retime_op(owbm_pkg::CMD_WRITE, WR_HOLD, owbm_pkg::REG_WRITE_SLOT, 10'd20, 10'd3);
        retime_op(owbm_pkg::CMD_READ, RD_LEAD, owbm_pkg::REG_READ_LEAD, 10'd20, 10'd2);
        retime_op(owbm_pkg::CMD_READ, RD_WAIT, owbm_pkg::REG_READ_SAMPLE, 10'd20, 10'd0);
        retime_op(owbm_pkg::CMD_RESET, RST_LOW, owbm_pkg::REG_RESET_LOW, 10'd20, 10'd9);
    endtask

    task automatic test_max_timing();
        drain();
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        plan_all(10'd1023);
        apply_timing();
        poll_low_left = 5;
        send_tick(owbm_pkg::CMD_RESET, 8'h00, pick_line());
        repeat (MAX_TICKS)
            send_tick(owbm_pkg::CMD_TICK, owbm_pkg::byte_t'($urandom), pick_line());
        drain();
        plan_all(10'd1);
        apply_timing();
        finish_op();
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned    hi;
        owbm_pkg::cmd_t c;
        for (int s = 0; s < RANDOM_SETS; s++) begin
            drain();
            hi = (s == 1) ? 12 : 3;
            for (int i = 0; i < NUM_REGS; i++)
                cfg_plan[i] = owbm_pkg::ticks_t'($urandom_range(0, hi));
            apply_timing();
            if (s == 2)
                rx_hold_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                if (bus_ph == BUS_IDLE)
                    c = ($urandom_range(0, 9) == 0) ? owbm_pkg::CMD_TICK
                                                     : owbm_pkg::cmd_t'($urandom_range(1, 3));
                else
                    c = busy_cmd();
                send_tick(c, owbm_pkg::byte_t'($urandom), pick_line());
            end
        end
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (tick_outputs_q.size() == 0) begin
                $display("%0t: result transfer with none outstanding, expected none, actual %0h",
                         $time, {m_drive_low, m_busy_res, m_rx_byte, m_done_res});
                mismatch_count++;
            end else begin
                want_out = tick_outputs_q.pop_front();
                check_field("drive_low", want_out.drive_low, m_drive_low);
                check_field("busy_res", want_out.busy_res, m_busy_res);
                check_field("rx_byte", want_out.rx_byte, m_rx_byte);
                check_field("done_res", want_out.done_res, m_done_res);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else if (rx_stall_en && $urandom_range(0, 99) < 30) begin
                m_ready <= 1'b0;
                repeat (pick_gap(1)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        reset_bus_copy();
        repeat (3) @(posedge aclk);
        aresetn     <= 1'b1;
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
        test_default_timing();
        test_zero_timing();
        test_byte_extremes();
        test_retime_mid_phase();
        test_max_timing();
        test_random_traffic();
        drain();
        repeat (DRAIN_PAD) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
